@@ rtl/core/llhist_pkg.sv @@
`default_nettype none

package llhist_pkg;

	// Defaults for the top-level parameters.
	localparam int MANT_BITS_DEF   = 5;
	localparam int NUM_BUCKETS_DEF = 1024;

	// Samples are cut to this many low bits before use.
	localparam int SAMPLE_BITS = 32;
	localparam int SMP_USE     = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
	localparam logic [31:0] SAMPLE_MASK = 32'((64'd1 << SMP_USE) - 64'd1);

	// Percentile scale: thousandths of a percent.
	localparam int PCT_W = 17;
	localparam logic [PCT_W-1:0] PCT_FULL = 17'd100000;

	// Width of (count - 1) * percentile.
	localparam int PROD_W = 32 + PCT_W;

	localparam logic MODE_RECORD = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef struct packed {
		logic rd_en;
		logic inc_en;
	} bkt_ctl_t;

	typedef struct packed {
		logic sq_en;
		logic commit;
	} stat_ctl_t;

	typedef struct packed {
		logic [31:0] count;
		logic [31:0] smallest;
		logic [31:0] largest;
		logic [63:0] sum;
		logic [63:0] sum_sq;
	} stats_t;

endpackage

`default_nettype wire

@@ rtl/core/llhist_stats.sv @@
`default_nettype none

module llhist_stats (
	input  wire                   clk,
	input  wire                   arst_n,
	input  llhist_pkg::stat_ctl_t ctl,
	input  wire  [31:0]           sample,
	output llhist_pkg::stats_t    stats
);

	logic [63:0] sq_s1;
	logic [31:0] count_q;
	logic [31:0] min_q;
	logic [31:0] max_q;
	logic [63:0] sum_q;
	logic [63:0] sum_sq_q;
	logic [64:0] sum_add;
	logic [64:0] sq_add;

	// The square is registered before it meets the accumulator.
	always_ff @(posedge clk) begin
		if (ctl.sq_en) begin
			sq_s1 <= sample * sample;
		end
	end

	assign sum_add = {1'b0, sum_q} + {33'd0, sample};
	assign sq_add  = {1'b0, sum_sq_q} + {1'b0, sq_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			min_q    <= '1;
			max_q    <= '0;
			sum_q    <= '0;
			sum_sq_q <= '0;
		end else if (ctl.commit) begin
			if (count_q != '1) begin
				count_q <= count_q + 32'd1;
			end
			if (sample < min_q) begin
				min_q <= sample;
			end
			if (sample > max_q) begin
				max_q <= sample;
			end
			sum_q    <= sum_add[64] ? '1 : sum_add[63:0];
			sum_sq_q <= sq_add[64] ? '1 : sq_add[63:0];
		end
	end

	assign stats = '{count: count_q, smallest: min_q, largest: max_q,
		sum: sum_q, sum_sq: sum_sq_q};

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> count_q != '0)
		else $error("sample count is zero after a recorded sample");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> min_q <= max_q)
		else $error("minimum above maximum after a recorded sample");

endmodule

`default_nettype wire

@@ rtl/core/llhist_buckets.sv @@
`default_nettype none

module llhist_buckets #(
	parameter int NUM_BUCKETS = llhist_pkg::NUM_BUCKETS_DEF,
	localparam int IDX_W = $clog2(NUM_BUCKETS)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  llhist_pkg::bkt_ctl_t ctl,
	input  wire  [IDX_W-1:0]     addr,
	output logic [31:0]          rd_data,
	output logic                 busy
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BUCKETS - 1);

	logic [31:0]      mem [NUM_BUCKETS];
	logic [31:0]      rd_q;
	logic [IDX_W-1:0] addr_s1;
	logic [IDX_W-1:0] clr_addr_q;
	logic             clearing_q;
	logic [31:0]      inc_val;

	// After reset the whole store is swept to zero, one entry a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (clr_addr_q == LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// An increment writes back to the entry read in the cycle before.
	assign inc_val = (rd_q == '1) ? rd_q : rd_q + 32'd1;

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.inc_en) begin
			mem[addr_s1] <= inc_val;
		end
		if (ctl.rd_en) begin
			rd_q    <= mem[addr];
			addr_s1 <= addr;
		end
	end

	assign rd_data = rd_q;
	assign busy    = clearing_q;

	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !(ctl.rd_en || ctl.inc_en))
		else $error("bucket store accessed during the clearing sweep");

endmodule

`default_nettype wire

@@ rtl/core/llhist_rank.sv @@
`default_nettype none

module llhist_rank (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire  [31:0]                       cnt_m1,
	input  wire  [llhist_pkg::PCT_W-1:0]      pct,
	output logic                              done,
	output logic [llhist_pkg::PROD_W-1:0]     target
);

	localparam int PW = llhist_pkg::PROD_W;

	// The walk tests a running total scaled by 100000 against this product,
	// which is the same as testing the unscaled total against the rank.
	logic [PW-1:0] target_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			target_q <= PW'(cnt_m1) * PW'(pct);
		end
	end

	assign done   = done_q;
	assign target = target_q;

endmodule

`default_nettype wire

@@ rtl/core/log_linear_latency_histogram.sv @@
// Channel | Direction | Beat content
// in      | into      | mode, sample_ns, percentile_milli
// out     | out of    | percentile_ns, sample_count, smallest_ns, largest_ns, sum_ns, sum_sq_ns
//
// A record beat runs from accept to accept through bucket read, increment write-back,
// result load and the return to idle; its result is valid once the result load is done.
// A query beat forms the scaled rank in S_RANK_GO and S_RANK_WAIT, then walks the buckets,
// one a cycle from the single read port, until the total passes the rank or the last is read.
// An empty query has no rank step or walk. After reset a sweep clears the buckets first.
// A stalled result holds only the final load, so a new beat may be accepted while out waits.
`default_nettype none

module log_linear_latency_histogram #(
	parameter int MANT_BITS   = llhist_pkg::MANT_BITS_DEF,
	parameter int NUM_BUCKETS = llhist_pkg::NUM_BUCKETS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         mode,
	input  wire  [31:0] sample_ns,
	input  wire  [16:0] percentile_milli,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] percentile_ns,
	output logic [31:0] sample_count,
	output logic [31:0] smallest_ns,
	output logic [31:0] largest_ns,
	output logic [63:0] sum_ns,
	output logic [63:0] sum_sq_ns
);

	localparam int IDX_W     = $clog2(NUM_BUCKETS);
	localparam int MANT_SPAN = 1 << MANT_BITS;
	localparam int SEEN_W    = IDX_W + 32;
	localparam int SCL_W     = SEEN_W + llhist_pkg::PCT_W;
	localparam int PW        = llhist_pkg::PROD_W;
	localparam logic [15:0]      LAST_B    = 16'(NUM_BUCKETS - 1);
	localparam logic [15:0]      MANT_MASK = 16'(MANT_SPAN - 1);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_BUCKETS - 1);
	localparam logic [IDX_W:0]   WALK_END  = (IDX_W + 1)'(NUM_BUCKETS);

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_REC_RD    = 8'b0000_0010,
		S_REC_WR    = 8'b0000_0100,
		S_RANK_GO   = 8'b0000_1000,
		S_RANK_WAIT = 8'b0001_0000,
		S_WALK      = 8'b0010_0000,
		S_MID       = 8'b0100_0000,
		S_DONE      = 8'b1000_0000
	} state_t;

	state_t                state_q;
	logic                  out_valid_q;
	logic [31:0]           smp_q;
	logic [16:0]           pct_q;
	logic [31:0]           result_q;
	logic [IDX_W:0]        walk_addr_q;
	logic                  rd_vld_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic [SCL_W-1:0]      seen_q;
	logic [IDX_W-1:0]      found_q;
	logic [31:0]           pct_ns_q;
	llhist_pkg::stats_t    out_stats_q;

	llhist_pkg::bkt_ctl_t  bctl;
	llhist_pkg::stat_ctl_t sctl;
	llhist_pkg::stats_t    stats;
	logic [IDX_W-1:0]      bkt_addr;
	logic [31:0]           bkt_rd;
	logic                  bkt_busy;
	logic                  rank_done;
	logic [PW-1:0]         target;
	logic [PW-1:0]         bkt_scl;
	logic                  accept;
	logic                  load_out;
	logic [SCL_W-1:0]      seen_nx;
	logic                  hit;
	logic                  last;

	// Bucket of the latched sample: top set bit and the mantissa bits below it.
	logic [5:0]       top_e;
	logic [31:0]      shr;
	logic [15:0]      grp;
	logic [15:0]      b_wide;
	logic [15:0]      b_clamp;
	logic [IDX_W-1:0] rec_idx;

	always_comb begin
		top_e = '0;
		for (int i = 0; i < 32; i++) begin
			if (smp_q[i]) begin
				top_e = 6'(i);
			end
		end
		shr = smp_q >> (top_e - 6'(MANT_BITS));
		grp = 16'(top_e) - 16'(MANT_BITS) + 16'd1;
		if (smp_q < 32'(MANT_SPAN)) begin
			b_wide = smp_q[15:0];
		end else begin
			b_wide = (grp << MANT_BITS) | (shr[15:0] & MANT_MASK);
		end
		b_clamp = (b_wide > LAST_B) ? LAST_B : b_wide;
		rec_idx = b_clamp[IDX_W-1:0];
	end

	// Midpoint of the bucket found by the walk.
	logic [15:0] mb;
	logic [15:0] me;
	logic [15:0] mm;
	logic [63:0] mval;
	logic [31:0] mid;

	always_comb begin
		mb   = 16'(found_q);
		me   = (mb >> MANT_BITS) + 16'(MANT_BITS) - 16'd1;
		mm   = mb & MANT_MASK;
		mval = '0;
		if (mb < 16'(MANT_SPAN)) begin
			mid = 32'(mb);
		end else if (me >= 16'd32) begin
			mid = '1;
		end else if (me == 16'(MANT_BITS)) begin
			mval = (64'd1 << me) + 64'(mm);
			mid  = mval[31:0];
		end else begin
			// One, the mantissa and a half-width step, shifted into place.
			mval = ((64'd1 << (MANT_BITS + 1)) | (64'(mm) << 1) | 64'd1)
				<< (me - 16'(MANT_BITS) - 16'd1);
			mid  = mval[31:0];
		end
	end

	assign in_ready = (state_q == S_IDLE) && !bkt_busy;
	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign bctl.rd_en  = (state_q == S_REC_RD) ||
		((state_q == S_WALK) && (walk_addr_q < WALK_END));
	assign bctl.inc_en = (state_q == S_REC_WR);
	assign bkt_addr    = (state_q == S_REC_RD) ? rec_idx : walk_addr_q[IDX_W-1:0];
	assign sctl.sq_en  = (state_q == S_REC_RD);
	assign sctl.commit = (state_q == S_REC_WR);

	// The running total passes the rank exactly when the total times 100000
	// exceeds (count - 1) * percentile, so no division is needed.
	assign bkt_scl = PW'(bkt_rd) * PW'(llhist_pkg::PCT_FULL);
	assign seen_nx = seen_q + SCL_W'(bkt_scl);
	assign hit     = rd_vld_s1 && (seen_nx > SCL_W'(target));
	assign last    = rd_idx_s1 == LAST_IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			walk_addr_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (mode == llhist_pkg::MODE_RECORD) begin
							state_q <= S_REC_RD;
						end else if (stats.count == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RANK_GO;
						end
					end
				end
				S_REC_RD:  state_q <= S_REC_WR;
				S_REC_WR:  state_q <= S_DONE;
				S_RANK_GO: state_q <= S_RANK_WAIT;
				S_RANK_WAIT: begin
					if (rank_done) begin
						state_q     <= S_WALK;
						walk_addr_q <= '0;
						rd_vld_s1   <= 1'b0;
					end
				end
				S_WALK: begin
					if (walk_addr_q < WALK_END) begin
						walk_addr_q <= walk_addr_q + (IDX_W + 1)'(1);
						rd_vld_s1   <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (hit) begin
						state_q <= S_MID;
					end else if (rd_vld_s1 && last) begin
						state_q <= S_DONE;
					end
				end
				S_MID: state_q <= S_DONE;
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					smp_q    <= sample_ns & llhist_pkg::SAMPLE_MASK;
					pct_q    <= (percentile_milli > llhist_pkg::PCT_FULL) ?
						llhist_pkg::PCT_FULL : percentile_milli;
					result_q <= '0;
				end
			end
			S_RANK_WAIT: begin
				seen_q <= '0;
			end
			S_WALK: begin
				rd_idx_s1 <= walk_addr_q[IDX_W-1:0];
				if (rd_vld_s1) begin
					seen_q <= seen_nx;
				end
				if (hit) begin
					found_q <= rd_idx_s1;
				end else if (rd_vld_s1 && last) begin
					// Saturated counters can leave the walk without a bucket.
					result_q <= stats.largest;
				end
			end
			S_MID: begin
				result_q <= mid;
			end
			S_DONE: begin
				if (load_out) begin
					pct_ns_q    <= result_q;
					out_stats_q <= stats;
				end
			end
			default: begin
			end
		endcase
	end

	llhist_buckets #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_buckets (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bctl),
		.addr   (bkt_addr),
		.rd_data(bkt_rd),
		.busy   (bkt_busy)
	);

	llhist_stats u_stats (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (sctl),
		.sample(smp_q),
		.stats (stats)
	);

	llhist_rank u_rank (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_RANK_GO),
		.cnt_m1(stats.count - 32'd1),
		.pct   (pct_q),
		.done  (rank_done),
		.target(target)
	);

	assign out_valid     = out_valid_q;
	assign percentile_ns = pct_ns_q;
	assign sample_count  = out_stats_q.count;
	assign smallest_ns   = out_stats_q.smallest;
	assign largest_ns    = out_stats_q.largest;
	assign sum_ns        = out_stats_q.sum;
	assign sum_sq_ns     = out_stats_q.sum_sq;

	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result register loaded outside the final step");

endmodule

`default_nettype wire

@@ tb/tb_log_linear_latency_histogram.sv @@
module tb_log_linear_latency_histogram;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MANT_BITS    = llhist_pkg::MANT_BITS_DEF;
	localparam int MANT_SPAN    = 1 << MANT_BITS;
	localparam int NUM_BUCKETS  = llhist_pkg::NUM_BUCKETS_DEF;
	localparam int RANDOM_BEATS = 780;

	typedef struct packed {
		logic [31:0]        pct_ns;
		llhist_pkg::stats_t stats;
	} hist_beat_t;

	typedef struct packed {
		logic        md;
		logic [31:0] smp;
		logic [16:0] pm;
		logic        typed;
		hist_beat_t  want;
	} stim_row_t;

	localparam hist_beat_t NO_WANT    = '0;
	localparam hist_beat_t EMPTY_WANT = '{32'd0, '{32'd0, 32'hFFFF_FFFF, 32'd0, 64'd0, 64'd0}};

	localparam stim_row_t OPENING_ROWS [17] = '{
		'{llhist_pkg::MODE_QUERY,  32'hFFFF_FFFF, 17'd50000,  1'b1, EMPTY_WANT},
		'{llhist_pkg::MODE_QUERY,  32'h0000_0000, 17'h1FFFF,  1'b1, EMPTY_WANT},
		'{llhist_pkg::MODE_RECORD, 32'd0,         17'h1FFFF,  1'b1,
			'{32'd0, '{32'd1, 32'd0, 32'd0, 64'd0, 64'd0}}},
		'{llhist_pkg::MODE_RECORD, 32'd1,         17'h1FFFF,  1'b1,
			'{32'd0, '{32'd2, 32'd0, 32'd1, 64'd1, 64'd1}}},
		'{llhist_pkg::MODE_QUERY,  32'hFFFF_FFFF, 17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'd31,        17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'd32,        17'd100000, 1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'd33,        17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'd63,        17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'd64,        17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'h0001_0000, 17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'd100000, 1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'd100001, 1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'h1FFFF,  1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'd50000,  1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'd1,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'd99999,  1'b0, NO_WANT}
	};

	// The widest samples come last, since the sum of squares saturates at once and stays there.
	localparam stim_row_t CLOSING_ROWS [8] = '{
		'{llhist_pkg::MODE_RECORD, 32'hFFFF_FFFF, 17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'h8000_0000, 17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'hFFFF_FFFF, 17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'd100000, 1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'h1FFFF,  1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_RECORD, 32'd0,         17'd0,      1'b0, NO_WANT},
		'{llhist_pkg::MODE_QUERY,  32'd0,         17'd50000,  1'b0, NO_WANT}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = llhist_pkg::MODE_RECORD;
	logic [31:0] sample_ns = '0;
	logic [16:0] percentile_milli = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] percentile_ns;
	logic [31:0] sample_count;
	logic [31:0] smallest_ns;
	logic [31:0] largest_ns;
	logic [63:0] sum_ns;
	logic [63:0] sum_sq_ns;

	// Shadow of the histogram state.
	logic [31:0] bucket_tally [NUM_BUCKETS];
	logic [31:0] seen_count;
	logic [31:0] low_ns;
	logic [31:0] high_ns;
	logic [63:0] total_ns;
	logic [63:0] total_sq_ns;

	hist_beat_t expected_beats [$];
	int         mismatches = 0;
	int         beats_sent = 0;
	int         results_seen = 0;

	log_linear_latency_histogram #(
		.MANT_BITS  (MANT_BITS),
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.sample_ns       (sample_ns),
		.percentile_milli(percentile_milli),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.percentile_ns   (percentile_ns),
		.sample_count    (sample_count),
		.smallest_ns     (smallest_ns),
		.largest_ns      (largest_ns),
		.sum_ns          (sum_ns),
		.sum_sq_ns       (sum_sq_ns)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned bucket_of(logic [31:0] ns);
		int unsigned msb;
		int unsigned idx;
		int          i;
		if (ns < MANT_SPAN) begin
			return ns;
		end
		msb = 0;
		for (i = 0; i < 32; i++) begin
			if (ns[i]) begin
				msb = i;
			end
		end
		idx = (msb - MANT_BITS + 1) * MANT_SPAN
			+ ((ns >> (msb - MANT_BITS)) & (MANT_SPAN - 1));
		return (idx >= NUM_BUCKETS) ? NUM_BUCKETS - 1 : idx;
	endfunction

	function automatic logic [31:0] bucket_midpoint(int unsigned b);
		int unsigned e;
		logic [63:0] w;
		if (b < MANT_SPAN) begin
			return 32'(b);
		end
		e = b / MANT_SPAN + MANT_BITS - 1;
		if (e >= 32) begin
			return '1;
		end
		w = 64'd1 << (e - MANT_BITS);
		return 32'((64'd1 << e) + 64'(b % MANT_SPAN) * w + w / 64'd2);
	endfunction

	function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// Applies one beat to the shadow state and returns the result it should produce.
	function automatic hist_beat_t histogram_step(logic md, logic [31:0] smp, logic [16:0] pm);
		hist_beat_t  r;
		logic [31:0] ns;
		int unsigned b;
		logic [63:0] p;
		logic [63:0] rank;
		logic [63:0] running;
		bit          hit;
		int          i;
		r = '0;
		if (md == llhist_pkg::MODE_RECORD) begin
			ns = smp & llhist_pkg::SAMPLE_MASK;
			b = bucket_of(ns);
			if (bucket_tally[b] != '1) begin
				bucket_tally[b] = bucket_tally[b] + 32'd1;
			end
			if (seen_count != '1) begin
				seen_count = seen_count + 32'd1;
			end
			if (ns < low_ns) begin
				low_ns = ns;
			end
			if (ns > high_ns) begin
				high_ns = ns;
			end
			total_ns = add_clamped(total_ns, 64'(ns));
			total_sq_ns = add_clamped(total_sq_ns, 64'(ns) * 64'(ns));
		end else if (seen_count != '0) begin
			p = (pm > llhist_pkg::PCT_FULL) ? 64'(llhist_pkg::PCT_FULL) : 64'(pm);
			rank = (64'(seen_count) - 64'd1) * p / 64'(llhist_pkg::PCT_FULL);
			running = '0;
			hit = 1'b0;
			for (i = 0; i < NUM_BUCKETS && !hit; i++) begin
				running = running + 64'(bucket_tally[i]);
				if (running > rank) begin
					r.pct_ns = bucket_midpoint(i);
					hit = 1'b1;
				end
			end
			if (!hit) begin
				r.pct_ns = high_ns;
			end
		end
		r.stats = '{seen_count, low_ns, high_ns, total_ns, total_sq_ns};
		return r;
	endfunction

	function automatic logic [31:0] draw_sample(int widest);
		int          w;
		logic [31:0] v;
		w = $urandom_range(0, widest);
		if (w == 0) begin
			return '0;
		end
		v = $urandom;
		if (w < 32) begin
			v = v & ((32'd1 << w) - 32'd1);
		end
		v[w-1] = 1'b1;
		return v;
	endfunction

	function automatic logic [16:0] draw_percentile();
		case ($urandom_range(0, 9))
			0: begin
				return 17'd0;
			end
			1: begin
				return llhist_pkg::PCT_FULL;
			end
			2: begin
				return 17'($urandom_range(100001, 131071));
			end
			default: begin
				return 17'($urandom_range(0, 100000));
			end
		endcase
	endfunction

	task automatic offer_beat(input logic md, input logic [31:0] smp, input logic [16:0] pm,
			input logic typed, input hist_beat_t typed_want);
		int         gap;
		hist_beat_t predicted;
		// Idle gaps come in stretches, with a run of back-to-back beats every third stretch.
		gap = (((beats_sent / 40) % 3) != 2) ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= md;
		sample_ns <= smp;
		percentile_milli <= pm;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = histogram_step(md, smp, pm);
		expected_beats.push_back(typed ? typed_want : predicted);
		beats_sent++;
	endtask

	task automatic compare_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
		end
	endtask

	initial begin
		int          n;
		int          widest;
		logic [31:0] smp;
		foreach (bucket_tally[k]) begin
			bucket_tally[k] = '0;
		end
		seen_count = '0;
		low_ns = '1;
		high_ns = '0;
		total_ns = '0;
		total_sq_ns = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING_ROWS[k]) begin
			offer_beat(OPENING_ROWS[k].md, OPENING_ROWS[k].smp, OPENING_ROWS[k].pm,
				OPENING_ROWS[k].typed, OPENING_ROWS[k].want);
		end

		for (n = 0; n < RANDOM_BEATS; n++) begin
			widest = (n >= RANDOM_BEATS - 60) ? 32 : 24;
			if ($urandom_range(0, 9) < 3) begin
				offer_beat(llhist_pkg::MODE_QUERY, $urandom, draw_percentile(), 1'b0,
					NO_WANT);
			end else begin
				smp = draw_sample(widest);
				offer_beat(llhist_pkg::MODE_RECORD, smp, 17'($urandom_range(0, 131071)),
					1'b0, NO_WANT);
			end
			if (n == 400) begin
				// Let the block drain completely before carrying on.
				in_valid <= 1'b0;
				while (expected_beats.size() != 0) @(posedge clk);
			end
		end

		foreach (CLOSING_ROWS[k]) begin
			offer_beat(CLOSING_ROWS[k].md, CLOSING_ROWS[k].smp, CLOSING_ROWS[k].pm,
				CLOSING_ROWS[k].typed, CLOSING_ROWS[k].want);
		end
		in_valid <= 1'b0;

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		int         gap;
		hist_beat_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (results_seen == 200) begin
				// A long hold-off on the output, so that the block backs up and stalls its input.
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			gap = (((results_seen / 64) % 2) == 0) ? $urandom_range(0, 3) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
			if (expected_beats.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with none expected, actual percentile_ns %h count %h",
					$time, percentile_ns, sample_count);
			end else begin
				want = expected_beats.pop_front();
				compare_field("percentile_ns", 64'(want.pct_ns), 64'(percentile_ns));
				compare_field("sample_count", 64'(want.stats.count), 64'(sample_count));
				compare_field("smallest_ns", 64'(want.stats.smallest), 64'(smallest_ns));
				compare_field("largest_ns", 64'(want.stats.largest), 64'(largest_ns));
				compare_field("sum_ns", want.stats.sum, sum_ns);
				compare_field("sum_sq_ns", want.stats.sum_sq, sum_sq_ns);
			end
		end
	end

	// Every beat a full-length query with the longest stalls, plus the clearing sweep, several times over.
	initial begin
		#40_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
